// File: sv/cva_pkg.sv
package cva_pkg;

    localparam int FIELD_W        = 16;
    localparam int DEF_STAGES     = 16;
    localparam int DEF_DATA_WIDTH = 16;
    localparam int GUARD_BITS     = 8;
    localparam int ANGLE_FRAC     = 24;
    localparam int OUT_FRAC       = 13;
    localparam int Z_W            = 28;
    localparam int TABLE_LEN      = 24;
    localparam int ITER_W         = 5;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int REG_IDX_W      = CFG_ADDR_W - 2;
    localparam int RES_W          = Z_W - (ANGLE_FRAC - OUT_FRAC);

    localparam logic [ITER_W-1:0]    ITER_RESET          = ITER_W'(16);
    localparam logic [REG_IDX_W-1:0] REG_ITERATION_COUNT = '0;

    localparam logic signed [Z_W-1:0] PI_FINE    = 28'sd52707179;
    localparam logic signed [Z_W-1:0] ROUND_BIAS = Z_W'(1) <<< (ANGLE_FRAC - OUT_FRAC - 1);
    localparam logic signed [RES_W-1:0] PI_RES   = 17'sd25736;

    localparam logic signed [Z_W-1:0] ATAN_FINE [TABLE_LEN] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2
    };

    typedef struct packed {
        logic neg_x;
        logic neg_y;
    } cva_quad_t;

    function automatic int cva_val_width(input int data_width);
        return (data_width > FIELD_W) ? FIELD_W + 1 : data_width + 1;
    endfunction

    function automatic int cva_path_width(input int data_width);
        return cva_val_width(data_width) + GUARD_BITS + 2;
    endfunction

endpackage

// File: sv/cva_prep.sv
module cva_prep #(
    parameter int DATA_WIDTH = cva_pkg::DEF_DATA_WIDTH,
    parameter int PATH_W     = cva_pkg::cva_path_width(cva_pkg::DEF_DATA_WIDTH)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [cva_pkg::FIELD_W-1:0]          in_x_coord,
    input  logic [cva_pkg::FIELD_W-1:0]          in_y_coord,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [PATH_W-1:0]             out_x,
    output logic signed [PATH_W-1:0]             out_y,
    output cva_pkg::cva_quad_t                   out_quad
);
    import cva_pkg::*;

    localparam int VAL_W = cva_val_width(DATA_WIDTH);
    localparam int PAD_W = PATH_W - VAL_W - GUARD_BITS;

    logic signed [VAL_W-1:0]  x_val;
    logic signed [VAL_W-1:0]  y_val;
    logic signed [VAL_W-1:0]  x_abs;
    logic signed [VAL_W-1:0]  y_abs;
    logic signed [PATH_W-1:0] x_next;
    logic signed [PATH_W-1:0] y_next;
    cva_quad_t                quad_next;
    logic                     valid_reg;
    logic signed [PATH_W-1:0] x_reg;
    logic signed [PATH_W-1:0] y_reg;
    cva_quad_t                quad_reg;

    // When DATA_WIDTH is wider than the fields, they are read as plain unsigned values.
    generate
        if (DATA_WIDTH > FIELD_W) begin : g_wide
            assign x_val = {1'b0, in_x_coord};
            assign y_val = {1'b0, in_y_coord};
        end else begin : g_narrow
            assign x_val = {in_x_coord[DATA_WIDTH-1], in_x_coord[DATA_WIDTH-1:0]};
            assign y_val = {in_y_coord[DATA_WIDTH-1], in_y_coord[DATA_WIDTH-1:0]};
        end
    endgenerate

    always_comb begin
        quad_next.neg_x = x_val[VAL_W-1];
        quad_next.neg_y = y_val[VAL_W-1];
        x_abs = quad_next.neg_x ? -x_val : x_val;
        y_abs = quad_next.neg_x ? -y_val : y_val;
        x_next = {{PAD_W{x_abs[VAL_W-1]}}, x_abs, {GUARD_BITS{1'b0}}};
        y_next = {{PAD_W{y_abs[VAL_W-1]}}, y_abs, {GUARD_BITS{1'b0}}};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_quad  = quad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            quad_reg <= quad_next;
        end
    end

endmodule

// File: sv/cva_stage.sv
module cva_stage #(
    parameter int PATH_W = cva_pkg::cva_path_width(cva_pkg::DEF_DATA_WIDTH),
    parameter int IDX    = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              active,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [PATH_W-1:0]          in_x,
    input  logic signed [PATH_W-1:0]          in_y,
    input  logic signed [cva_pkg::Z_W-1:0]    in_z,
    input  cva_pkg::cva_quad_t                in_quad,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [PATH_W-1:0]          out_x,
    output logic signed [PATH_W-1:0]          out_y,
    output logic signed [cva_pkg::Z_W-1:0]    out_z,
    output cva_pkg::cva_quad_t                out_quad
);
    import cva_pkg::*;

    logic signed [PATH_W-1:0] sx;
    logic signed [PATH_W-1:0] sy;
    logic signed [PATH_W-1:0] x_next;
    logic signed [PATH_W-1:0] y_next;
    logic signed [Z_W-1:0]    z_next;
    logic                     valid_reg;
    logic signed [PATH_W-1:0] x_reg;
    logic signed [PATH_W-1:0] y_reg;
    logic signed [Z_W-1:0]    z_reg;
    cva_quad_t                quad_reg;

    always_comb begin
        sx = in_x >>> IDX;
        sy = in_y >>> IDX;
        x_next = in_x;
        y_next = in_y;
        z_next = in_z;
        if (active) begin
            if (!in_y[PATH_W-1]) begin
                x_next = in_x + sy;
                y_next = in_y - sx;
                z_next = in_z + ATAN_FINE[IDX];
            end else begin
                x_next = in_x - sy;
                y_next = in_y + sx;
                z_next = in_z - ATAN_FINE[IDX];
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_quad  = quad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            quad_reg <= in_quad;
        end
    end

endmodule

// File: sv/cva_post.sv
module cva_post (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [cva_pkg::Z_W-1:0]    in_z,
    input  cva_pkg::cva_quad_t                in_quad,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cva_pkg::FIELD_W-1:0]       out_angle
);
    import cva_pkg::*;

    logic signed [Z_W-1:0]     corr;
    logic signed [Z_W-1:0]     z_fix;
    logic signed [Z_W-1:0]     z_rnd;
    logic signed [RES_W-1:0]   res;
    logic signed [FIELD_W-1:0] angle_next;
    logic                      valid_reg;
    logic [FIELD_W-1:0]        angle_reg;

    // Items that were turned by 180 degrees get pi back, with the sign of y.
    always_comb begin
        corr = '0;
        if (in_quad.neg_x) begin
            corr = in_quad.neg_y ? -PI_FINE : PI_FINE;
        end
        z_fix = in_z + corr;
        z_rnd = z_fix + ROUND_BIAS;
        res   = z_rnd[Z_W-1:ANGLE_FRAC-OUT_FRAC];
        priority if (res > PI_RES) begin
            angle_next = FIELD_W'(PI_RES);
        end else if (res < -PI_RES) begin
            angle_next = FIELD_W'(-PI_RES);
        end else begin
            angle_next = res[FIELD_W-1:0];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_angle = angle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            angle_reg <= angle_next;
        end
    end

endmodule

// File: sv/cordic_vectoring_atan2.sv
// CORDIC vectoring atan2. Each item carries x_coord and y_coord (16-bit signed)
// and yields one angle, atan2(y, x) in radians as signed Q3.13, held to
// [-pi, pi] with pi = 25736. One item is accepted per clock unless the output
// stalls. Its stages: an input conditioning stage (180-degree turn for negative
// x and guard-bit scaling), one registered stage per built micro-rotation, and
// an output stage that restores pi, rounds and saturates. Register
// iteration_count (address 0, reset 16) sets how many micro-rotations act;
// values above STAGES act as STAGES, and it is to be written only while no item
// is in flight. Each stage holds its item when the next one is full, so empty
// stages still take new items while a result waits on the output.
module cordic_vectoring_atan2 #(
    parameter int STAGES     = cva_pkg::DEF_STAGES,
    parameter int DATA_WIDTH = cva_pkg::DEF_DATA_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [2*cva_pkg::FIELD_W-1:0]        s_axis_tdata,  // x_coord, y_coord
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [cva_pkg::FIELD_W-1:0]          m_axis_tdata,  // angle
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cva_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [cva_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [cva_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import cva_pkg::*;

    localparam int PATH_W = cva_path_width(DATA_WIDTH);

    logic [ITER_W-1:0]        iter_reg;
    logic [ITER_W-1:0]        iter_next;
    logic                     cfg_wr;
    logic [REG_IDX_W-1:0]     reg_idx;

    logic [STAGES:0]          vld;
    logic [STAGES:0]          rdy;
    logic signed [PATH_W-1:0] xs [STAGES+1];
    logic signed [PATH_W-1:0] ys [STAGES+1];
    logic signed [Z_W-1:0]    zs [STAGES+1];
    cva_quad_t                qs [STAGES+1];
    logic signed [FIELD_W-1:0] angle_chk;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (reg_idx == REG_ITERATION_COUNT);
    assign pready  = 1'b1;
    assign iter_next = pwdata[ITER_W-1:0];

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_ITERATION_COUNT) begin
            prdata = CFG_DATA_W'(iter_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_reg <= ITER_RESET;
        end else if (cfg_wr) begin
            iter_reg <= iter_next;
        end
    end

    cva_prep #(
        .DATA_WIDTH (DATA_WIDTH),
        .PATH_W     (PATH_W)
    ) u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_x_coord (s_axis_tdata[FIELD_W-1:0]),
        .in_y_coord (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .out_valid  (vld[0]),
        .out_ready  (rdy[0]),
        .out_x      (xs[0]),
        .out_y      (ys[0]),
        .out_quad   (qs[0])
    );

    assign zs[0] = '0;

    generate
        for (genvar i = 0; i < STAGES; i++) begin : g_stage
            logic active;

            assign active = iter_reg > ITER_W'(i);

            cva_stage #(
                .PATH_W (PATH_W),
                .IDX    (i)
            ) u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .active    (active),
                .in_valid  (vld[i]),
                .in_ready  (rdy[i]),
                .in_x      (xs[i]),
                .in_y      (ys[i]),
                .in_z      (zs[i]),
                .in_quad   (qs[i]),
                .out_valid (vld[i+1]),
                .out_ready (rdy[i+1]),
                .out_x     (xs[i+1]),
                .out_y     (ys[i+1]),
                .out_z     (zs[i+1]),
                .out_quad  (qs[i+1])
            );
        end
    endgenerate

    cva_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld[STAGES]),
        .in_ready  (rdy[STAGES]),
        .in_z      (zs[STAGES]),
        .in_quad   (qs[STAGES]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_angle (m_axis_tdata)
    );

    assign angle_chk = m_axis_tdata;

    // The input side can only be held off when the output holds a waiting item.
    a_stall_needs_full_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output stage could move");

    a_angle_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((angle_chk <= FIELD_W'(PI_RES)) && (angle_chk >= FIELD_W'(-PI_RES))))
        else $error("angle outside of [-pi, pi]");

    a_cfg_write_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> (iter_reg == $past(iter_next)))
        else $error("iteration_count write not taken");

    a_empty_pipe_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld == '0) && !s_axis_tvalid |=> (vld[0] == 1'b0))
        else $error("item appeared in an empty pipeline");

endmodule

// File: verif/cva_checker.sv
`timescale 1ns / 1ps

module cva_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [2*cva_pkg::FIELD_W-1:0]     s_axis_tdata,  // x_coord, y_coord
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [cva_pkg::FIELD_W-1:0]       m_axis_tdata,  // angle
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cva_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [cva_pkg::CFG_DATA_W-1:0]    pwdata,
    input  logic [cva_pkg::CFG_DATA_W-1:0]    prdata,
    input  logic                              pready,
    output int                                fail_count,
    output int                                pending_count,
    output int                                items_in,
    output int                                angles_out
);

    typedef struct packed {
        logic signed [15:0] y_coord;
        logic signed [15:0] x_coord;
    } coord_pair_t;

    localparam int                            BUILT_STAGES  = 16;
    localparam logic [4:0]                    ITER_AT_RESET = 5'd16;
    localparam logic [cva_pkg::CFG_ADDR_W-1:0] ITER_ADDR    =
        cva_pkg::CFG_ADDR_W'(cva_pkg::REG_ITERATION_COUNT) << 2;
    localparam longint                        PI_SCALED     = 52707179;
    localparam longint                        PI_Q13_LIMIT  = 25736;
    localparam int                            PRINT_CAP     = 50;

    // round(atan(2^-i) * 2^24)
    localparam longint ATAN_STEP [BUILT_STAGES] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512
    };

    logic [4:0]  iter_setting = ITER_AT_RESET;
    logic [15:0] angle_queue [$];
    int          errors = 0;
    int          accepted = 0;
    int          compared = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        items_in      = 0;
        angles_out    = 0;
    end

    function automatic logic [15:0] atan2_q13(input coord_pair_t item, input logic [4:0] iters);
        longint x;
        longint y;
        longint sx;
        longint sy;
        longint z;
        longint res;
        int     n;
        bit     neg_x;
        bit     neg_y;
        x     = longint'(item.x_coord);
        y     = longint'(item.y_coord);
        neg_x = x < 0;
        neg_y = y < 0;
        n     = (iters > BUILT_STAGES) ? BUILT_STAGES : int'(iters);
        z     = 0;
        if (neg_x) begin
            x = -x;
            y = -y;
        end
        x = x <<< 8;
        y = y <<< 8;
        for (int i = 0; i < n; i++) begin
            sx = x >>> i;
            sy = y >>> i;
            if (y >= 0) begin
                x = x + sy;
                y = y - sx;
                z = z + ATAN_STEP[i];
            end else begin
                x = x - sy;
                y = y + sx;
                z = z - ATAN_STEP[i];
            end
        end
        if (neg_x) begin
            z = neg_y ? z - PI_SCALED : z + PI_SCALED;
        end
        res = (z + 1024) >>> 11;
        if (res > PI_Q13_LIMIT) begin
            res = PI_Q13_LIMIT;
        end
        if (res < -PI_Q13_LIMIT) begin
            res = -PI_Q13_LIMIT;
        end
        return res[15:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] expected,
                                   input logic [31:0] got);
        errors++;
        if (errors <= PRINT_CAP) begin
            $display("[%0t] %s: expected 0x%h, got 0x%h", $time, what, expected, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            iter_setting <= ITER_AT_RESET;
            angle_queue.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite && paddr == ITER_ADDR) begin
                    iter_setting <= pwdata[4:0];
                end
                if (!pwrite && paddr == ITER_ADDR && prdata !== {27'd0, iter_setting}) begin
                    report_mismatch("iteration_count readback", {27'd0, iter_setting}, prdata);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                angle_queue.push_back(atan2_q13(s_axis_tdata, iter_setting));
                accepted++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (angle_queue.size() == 0) begin
                    report_mismatch("angle with no item pending", 32'd0, 32'(m_axis_tdata));
                end else begin
                    if (m_axis_tdata !== angle_queue[0]) begin
                        report_mismatch("angle", 32'(angle_queue[0]), 32'(m_axis_tdata));
                    end
                    void'(angle_queue.pop_front());
                    compared++;
                end
            end
        end
        fail_count    <= errors;
        pending_count <= angle_queue.size();
        items_in      <= accepted;
        angles_out    <= compared;
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int                             PHASES         = 10;
    localparam int                             ITEMS_PER_PHASE = 130;
    localparam int                             DIRECTED_ITEMS = 20;
    localparam int                             SETTLE_CYCLES  = 24;
    localparam logic [cva_pkg::CFG_ADDR_W-1:0] ITER_ADDR      =
        cva_pkg::CFG_ADDR_W'(cva_pkg::REG_ITERATION_COUNT) << 2;
    localparam logic [cva_pkg::CFG_ADDR_W-1:0] SPARE_ADDR     = 3'd4;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // x_coord [15:0], y_coord [31:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // angle [15:0]
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [cva_pkg::CFG_ADDR_W-1:0] paddr  = '0;
    logic [cva_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [cva_pkg::CFG_DATA_W-1:0] prdata;
    logic        pready;

    int fail_count;
    int pending_count;
    int items_in;
    int angles_out;

    int burst_left  = 1;
    int stall_mode  = 0;
    int stall_left  = 0;
    int stall_phase = 0;

    shortint dir_x [DIRECTED_ITEMS] = '{
        32767, -32768, 0, 0, 0, 32767, -32768, -32768, 32767, -1,
        -1, -1, 1, 1, 0, 0, -5, 100, -32768, -32767
    };
    shortint dir_y [DIRECTED_ITEMS] = '{
        0, 0, 0, 32767, -32768, 32767, -32768, 32767, -32768, 0,
        -1, 1, -1, 1, 1, -1, 0, -3, -1, 1
    };
    int iter_plan [PHASES] = '{16, 0, 1, 31, 17, 8, 2, 15, 24, 16};

    cordic_vectoring_atan2 dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    cva_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .items_in      (items_in),
        .angles_out    (angles_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // The result side switches among several stall styles, each held for a while.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(40, 250);
            end
            stall_left--;
            stall_phase++;
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ((stall_phase % 29) >= 20);
            endcase
        end
    end

    function automatic shortint pick_coord();
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return shortint'(int'($urandom_range(0, 8)) - 4);
            4: return shortint'(int'($urandom_range(0, 255)) - 128);
            default: return shortint'($urandom());
        endcase
    endfunction

    task automatic send_item(input shortint x, input shortint y);
        s_axis_tdata  <= {y, x};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        burst_left--;
        if (burst_left == 0) begin
            int gap;
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 64);
        end
    endtask

    task automatic apb_access(input logic wr, input logic [cva_pkg::CFG_ADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int n_items;
        iter_plan[6] = $urandom_range(3, 14);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_access(1'b0, ITER_ADDR, '0);
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain_pipeline();
                if (p == 5) begin
                    apb_access(1'b1, SPARE_ADDR, $urandom());
                end
                apb_access(1'b1, ITER_ADDR, ($urandom() & ~32'h1f) | iter_plan[p]);
                apb_access(1'b0, ITER_ADDR, '0);
            end
            n_items = ITEMS_PER_PHASE;
            if (p == 0) begin
                for (int i = 0; i < DIRECTED_ITEMS; i++) begin
                    send_item(dir_x[i], dir_y[i]);
                end
                n_items = ITEMS_PER_PHASE - DIRECTED_ITEMS;
            end
            for (int i = 0; i < n_items; i++) begin
                send_item(pick_coord(), pick_coord());
            end
        end
        drain_pipeline();
        $display("Sent %0d vectors over %0d iteration_count settings, %0d angles checked.",
                 items_in, PHASES, angles_out);
        if (fail_count == 0 && pending_count == 0) begin
            $display("cordic_vectoring_atan2: match");
        end else begin
            $display("cordic_vectoring_atan2: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d angles still pending.", pending_count);
        $display("cordic_vectoring_atan2: mismatch");
        $finish;
    end

endmodule
